// ===== rtl/core/obb2d_pkg.sv =====
`timescale 1ns / 1ps

package obb2d_pkg;

	localparam int COORD_W  = 24;
	localparam int HALF_W   = COORD_W - 2;
	localparam int ANG_FRAC = 14;
	localparam int ANG_W    = ANG_FRAC + 2;

	localparam int D_W      = COORD_W + 1;
	localparam int PD_W     = D_W + ANG_W;
	localparam int CP_W     = PD_W + 1;
	localparam int AA_W     = 2 * ANG_W;
	localparam int PQ_W     = AA_W + 1;
	localparam int EXT_W    = PQ_W + HALF_W;
	localparam int SUM_W    = EXT_W + 2;

	localparam int IN_BITS  = 4 * COORD_W + 4 * HALF_W + 4 * ANG_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_W    = 8;

	localparam int N_AXES   = 4;

	typedef struct packed {
		logic signed [ANG_W-1:0]   b_sin;
		logic signed [ANG_W-1:0]   b_cos;
		logic [HALF_W-1:0]         b_half_y;
		logic [HALF_W-1:0]         b_half_x;
		logic signed [COORD_W-1:0] b_center_y;
		logic signed [COORD_W-1:0] b_center_x;
		logic signed [ANG_W-1:0]   a_sin;
		logic signed [ANG_W-1:0]   a_cos;
		logic [HALF_W-1:0]         a_half_y;
		logic [HALF_W-1:0]         a_half_x;
		logic signed [COORD_W-1:0] a_center_y;
		logic signed [COORD_W-1:0] a_center_x;
	} obb_in_t;

endpackage

// ===== rtl/core/obb_overlap_test_2d_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one box pair per cycle unless m_tready stalls the output,
// through a six-stage pipeline (difference, products, sums, extent
// products, alignment, compare).
// Each stage holds its item while the stage after it is full and stalled.
// Reset (arst_n, asynchronous, active low) clears the stage valid bits only.

module obb_overlap_test_2d_unit import obb2d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// a_center_x, a_center_y, a_half_x, a_half_y, a_cos, a_sin,
	// b_center_x, b_center_y, b_half_x, b_half_y, b_cos, b_sin
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// hit, zero padding
	output logic [OUT_W-1:0] m_tdata
);

	obb_in_t in_w;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic signed [D_W-1:0]   dx_s1, dy_s1;
	logic signed [ANG_W-1:0] ac_s1, as_s1, bc_s1, bs_s1;
	logic [HALF_W-1:0]       hv_s1 [N_AXES];

	logic signed [PD_W-1:0]  dxac_s2, dyas_s2, dxas_s2, dyac_s2;
	logic signed [PD_W-1:0]  dxbc_s2, dybs_s2, dxbs_s2, dybc_s2;
	logic signed [AA_W-1:0]  acbc_s2, asbs_s2, asbc_s2, acbs_s2;
	logic [HALF_W-1:0]       hv_s2 [N_AXES];

	logic signed [CP_W-1:0]  cp_w [N_AXES];
	logic signed [PQ_W-1:0]  p_w, q_w;
	logic [CP_W-1:0]         cpm_s3 [N_AXES];
	logic [PQ_W-1:0]         pm_s3, qm_s3;
	logic [HALF_W-1:0]       hv_s3 [N_AXES];

	logic [EXT_W-1:0]        e0_s4 [N_AXES];
	logic [EXT_W-1:0]        e1_s4 [N_AXES];
	logic [CP_W-1:0]         cpm_s4 [N_AXES];
	logic [HALF_W-1:0]       hv_s4 [N_AXES];

	logic [SUM_W-1:0]        lhs_s5 [N_AXES];
	logic [SUM_W-1:0]        rhs_s5 [N_AXES];

	logic                    hit_s6;

	assign in_w = obb_in_t'(s_tdata[IN_BITS-1:0]);

	assign en6 = !v_s6 || m_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_tready = en1;
	assign m_tvalid = v_s6;
	assign m_tdata  = {{(OUT_W-1){1'b0}}, hit_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dx_s1    <= D_W'(in_w.a_center_x) - D_W'(in_w.b_center_x);
			dy_s1    <= D_W'(in_w.a_center_y) - D_W'(in_w.b_center_y);
			ac_s1    <= in_w.a_cos;
			as_s1    <= in_w.a_sin;
			bc_s1    <= in_w.b_cos;
			bs_s1    <= in_w.b_sin;
			hv_s1[0] <= in_w.a_half_x;
			hv_s1[1] <= in_w.a_half_y;
			hv_s1[2] <= in_w.b_half_x;
			hv_s1[3] <= in_w.b_half_y;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			dxac_s2 <= dx_s1 * ac_s1;
			dyas_s2 <= dy_s1 * as_s1;
			dxas_s2 <= dx_s1 * as_s1;
			dyac_s2 <= dy_s1 * ac_s1;
			dxbc_s2 <= dx_s1 * bc_s1;
			dybs_s2 <= dy_s1 * bs_s1;
			dxbs_s2 <= dx_s1 * bs_s1;
			dybc_s2 <= dy_s1 * bc_s1;
			acbc_s2 <= ac_s1 * bc_s1;
			asbs_s2 <= as_s1 * bs_s1;
			asbc_s2 <= as_s1 * bc_s1;
			acbs_s2 <= ac_s1 * bs_s1;
			hv_s2   <= hv_s1;
		end
	end

	// Both boxes are rotations, so the four cross projections reduce to
	// the magnitudes of two terms, P and Q.
	always_comb begin
		cp_w[0] = CP_W'(dxac_s2) + CP_W'(dyas_s2);
		cp_w[1] = CP_W'(dyac_s2) - CP_W'(dxas_s2);
		cp_w[2] = CP_W'(dxbc_s2) + CP_W'(dybs_s2);
		cp_w[3] = CP_W'(dybc_s2) - CP_W'(dxbs_s2);
		p_w     = PQ_W'(acbc_s2) + PQ_W'(asbs_s2);
		q_w     = PQ_W'(asbc_s2) - PQ_W'(acbs_s2);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int k = 0; k < N_AXES; k++) begin
				cpm_s3[k] <= cp_w[k][CP_W-1] ? $unsigned(-cp_w[k]) : $unsigned(cp_w[k]);
			end
			pm_s3 <= p_w[PQ_W-1] ? $unsigned(-p_w) : $unsigned(p_w);
			qm_s3 <= q_w[PQ_W-1] ? $unsigned(-q_w) : $unsigned(q_w);
			hv_s3 <= hv_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			e0_s4[0] <= pm_s3 * hv_s3[2];
			e1_s4[0] <= qm_s3 * hv_s3[3];
			e0_s4[1] <= qm_s3 * hv_s3[2];
			e1_s4[1] <= pm_s3 * hv_s3[3];
			e0_s4[2] <= pm_s3 * hv_s3[0];
			e1_s4[2] <= qm_s3 * hv_s3[1];
			e0_s4[3] <= qm_s3 * hv_s3[0];
			e1_s4[3] <= pm_s3 * hv_s3[1];
			cpm_s4   <= cpm_s3;
			hv_s4    <= hv_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < N_AXES; k++) begin
				lhs_s5[k] <= (SUM_W'(hv_s4[k]) << (2 * ANG_FRAC))
					+ SUM_W'(e0_s4[k]) + SUM_W'(e1_s4[k]);
				rhs_s5[k] <= SUM_W'(cpm_s4[k]) << ANG_FRAC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			hit_s6 <= (lhs_s5[0] > rhs_s5[0]) && (lhs_s5[1] > rhs_s5[1])
				&& (lhs_s5[2] > rhs_s5[2]) && (lhs_s5[3] > rhs_s5[3]);
		end
	end

`ifndef ASSERT_OFF
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s6 |-> s_tready)
		else $error("input stalled while the output stage is empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted transaction did not enter the first stage");

	a_stage_advances: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en4 |=> v_s4)
		else $error("item lost between the third and fourth stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en5 |=> v_s5 && $stable(lhs_s5[0]) && $stable(rhs_s5[0]))
		else $error("stalled fifth stage changed its contents");
`endif

endmodule
